// ----- hw/rtl/taylor_pkg.sv -----
// ----------------------------------------------------------------------------
// Taylor partial sums package
// Function codes, fixed-point constants and field widths used by the core.
// ----------------------------------------------------------------------------
package taylor_pkg;

  // Function selection codes
  typedef enum logic [1:0] {
    MODE_SIN  = 2'd0,
    MODE_COS  = 2'd1,
    MODE_EXP  = 2'd2,
    MODE_LN1P = 2'd3
  } mode_e;

  localparam int XW     = 32;  // argument, Q4.28
  localparam int SW     = 64;  // sums and terms, Q31.32
  localparam int CFG_W  = 6;
  localparam int IDX_W  = 5;

  localparam logic [CFG_W-1:0] TERM_COUNT_RST = 6'd11;

  // 1.0 in Q31.32 and the ln(1+x) domain bound 1.0 in Q4.28
  localparam logic signed [SW-1:0] ONE_Q32  = 64'sh0000_0001_0000_0000;
  localparam logic signed [XW-1:0] ONE_Q28  = 32'sh1000_0000;
  localparam logic signed [XW-1:0] MONE_Q28 = -32'sh1000_0000;

  localparam logic signed [SW-1:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [SW-1:0] SUM_MIN = 64'sh8000_0000_0000_0000;

  // Divider: four quotient bits per cycle over a 64-bit dividend
  localparam int DIV_BITS   = 4;
  localparam int DIV_CYCLES = SW / DIV_BITS;

endpackage

// ----- hw/rtl/taylor_if.sv -----
// ----------------------------------------------------------------------------
// Taylor partial sums channels
// Valid/ready channels for argument beats and result beats.
// ----------------------------------------------------------------------------
interface taylor_in_if;
  logic                  valid;
  logic                  ready;
  logic signed [31:0]    x_value;
  logic [1:0]            mode;

  modport source (output valid, x_value, mode, input ready);
  modport sink   (input valid, x_value, mode, output ready);
endinterface

interface taylor_out_if;
  logic                  valid;
  logic                  ready;
  logic signed [63:0]    partial_sum;
  logic [4:0]            term_index;
  logic                  reverse_order;
  logic                  domain_error;
  logic                  overflowed;
  logic                  last_result;

  modport source (output valid, partial_sum, term_index, reverse_order, domain_error,
                  overflowed, last_result, input ready);
  modport sink   (input valid, partial_sum, term_index, reverse_order, domain_error,
                  overflowed, last_result, output ready);
endinterface

// ----- hw/rtl/taylor_ram.sv -----
// ----------------------------------------------------------------------------
// Taylor generic RAM
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module taylor_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/taylor_series_partial_sums_core.sv -----
// ----------------------------------------------------------------------------
// Taylor series partial sums core
// Term 0 is written in S_INIT; each further term runs S_MUL_LO, S_MUL_HI and
//   S_MUL_FIX on the shared 32x32 multiplier (twice for sin, cos), the
//   4-bit-per-cycle divider and S_WRITE. Each beat of the forward pass, the
//   suffix pass and the suffix readout takes a read and an add/emit state.
// Throughput: one argument at a time; a domain error emits a single beat.
// Reset: async active low; term count back to 11, FSM idle, output empty.
// ----------------------------------------------------------------------------
module taylor_series_partial_sums_core #(
  parameter int MAX_TERMS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [5:0]                cfg_wdata_i,
  taylor_in_if.sink                 in_i,
  taylor_out_if.source              out_o
);

  localparam int AW   = $clog2(MAX_TERMS);
  localparam int CW   = $clog2(MAX_TERMS + 1);
  localparam int DMAX = 2 * (MAX_TERMS - 1) * (2 * MAX_TERMS - 1);
  localparam int DW   = $clog2(DMAX + 1);
  localparam int SW   = taylor_pkg::SW;
  localparam int XW   = taylor_pkg::XW;
  localparam int DCW  = $clog2(taylor_pkg::DIV_CYCLES);

  localparam logic [CW-1:0]  N_MAX  = CW'(MAX_TERMS);
  localparam logic [CW-1:0]  N_MIN  = CW'(2);
  localparam logic [DCW-1:0] DC_END = DCW'(taylor_pkg::DIV_CYCLES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DOM, S_INIT, S_MUL_LO, S_MUL_HI, S_MUL_FIX, S_DIV, S_WRITE,
    S_FWD_RD, S_FWD_ADD, S_REV_RD, S_REV_ADD, S_OUT_RD, S_OUT_EMIT
  } state_e;

  // Saturating from sign and magnitude
  function automatic logic [SW-1:0] from_mag(input logic neg, input logic [SW-1:0] m);
    logic [SW-1:0] r;
    if (neg) begin
      r = m[SW-1] ? taylor_pkg::SUM_MIN : (~m + SW'(1));
    end else begin
      r = m[SW-1] ? taylor_pkg::SUM_MAX : m;
    end
    return r;
  endfunction

  // Saturating add, overflow flag on top
  function automatic logic [SW:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW-1:0] s;
    logic [SW:0]   r;
    s = a + b;
    if (!a[SW-1] && !b[SW-1] && s[SW-1]) begin
      r = {1'b1, taylor_pkg::SUM_MAX};
    end else if (a[SW-1] && b[SW-1] && !s[SW-1]) begin
      r = {1'b1, taylor_pkg::SUM_MIN};
    end else begin
      r = {1'b0, s};
    end
    return r;
  endfunction

  state_e                  state_q;
  logic [5:0]              tc_q;
  logic [CW-1:0]           n_q, i_q;
  taylor_pkg::mode_e       mode_q;
  logic                    xneg_q;
  logic [XW-1:0]           xmag_q;
  logic [SW-1:0]           mop_q;
  logic                    second_q;
  logic [SW-1:0]           lo_q, hi_q;
  logic [DW-1:0]           divisor_q;
  logic [SW-1:0]           dq_q;
  logic [DW-1:0]           rem_q;
  logic [DCW-1:0]          dcnt_q;
  logic                    dneg_q;
  logic [SW-1:0]           sum_q;
  logic                    ovf_q;

  logic                    out_valid_q;
  logic [SW-1:0]           out_sum_q;
  logic [4:0]              out_idx_q;
  logic                    out_rev_q, out_dom_q, out_ovf_q, out_last_q;

  // Clamped term count
  logic [CW-1:0] n_clamp;
  always_comb begin
    if (tc_q < 6'd2) begin
      n_clamp = N_MIN;
    end else if (tc_q > 6'(MAX_TERMS)) begin
      n_clamp = N_MAX;
    end else begin
      n_clamp = CW'(tc_q);
    end
  end

  // Argument decode at accept
  taylor_pkg::mode_e in_mode;
  logic              in_dom;
  logic [SW-1:0]     t0;
  assign in_mode = taylor_pkg::mode_e'(in_i.mode);
  assign in_dom  = (in_mode == taylor_pkg::MODE_LN1P) &&
                   ((in_i.x_value >= taylor_pkg::ONE_Q28) ||
                    (in_i.x_value <= taylor_pkg::MONE_Q28));

  // Shared 32x32 multiplier over the operand magnitude
  logic [SW-1:0] mop_mag;
  logic [31:0]   mul_a;
  logic [SW-1:0] prod;
  assign mop_mag = mop_q[SW-1] ? (~mop_q + SW'(1)) : mop_q;
  assign mul_a   = (state_q == S_MUL_LO) ? mop_mag[31:0] : mop_mag[63:32];
  assign prod    = mul_a * xmag_q;

  // Recombine partial products: (t*x) >> 28, saturating
  logic [SW-1:0] mmag, mres, mres_mag;
  assign mmag     = (hi_q[63:59] != 5'd0) ? {SW{1'b1}} : ((hi_q << 4) + (lo_q >> 28));
  assign mres     = from_mag(mop_q[SW-1] ^ xneg_q, mmag);
  assign mres_mag = mres[SW-1] ? (~mres + SW'(1)) : mres;

  // Divisor for term i
  logic [DW-1:0] two_i, i_d, divisor;
  assign i_d   = DW'(i_q);
  assign two_i = DW'({i_q, 1'b0});
  always_comb begin
    case (mode_q)
      taylor_pkg::MODE_SIN: divisor = DW'(two_i * (two_i + DW'(1)));
      taylor_pkg::MODE_COS: divisor = DW'((two_i - DW'(1)) * two_i);
      taylor_pkg::MODE_EXP: divisor = i_d;
      default:              divisor = i_d + DW'(1);
    endcase
  end

  logic negate;
  assign negate = (mode_q == taylor_pkg::MODE_SIN) || (mode_q == taylor_pkg::MODE_COS) ||
                  ((mode_q == taylor_pkg::MODE_LN1P) && i_q[0]);

  // Restoring divider, four bits per cycle
  logic [SW-1:0] dq_d;
  logic [DW-1:0] rem_d;
  always_comb begin
    logic [DW:0] r;
    dq_d  = dq_q;
    rem_d = rem_q;
    for (int k = 0; k < taylor_pkg::DIV_BITS; k++) begin
      r    = {rem_d, dq_d[SW-1]};
      dq_d = {dq_d[SW-2:0], 1'b0};
      if (r >= {1'b0, divisor_q}) begin
        r       = r - {1'b0, divisor_q};
        dq_d[0] = 1'b1;
      end
      rem_d = r[DW-1:0];
    end
  end

  logic [SW-1:0] t_div;
  assign t_div = from_mag(dneg_q, dq_q);

  // Term store and suffix store
  logic              term_we;
  logic [SW-1:0]     term_wdata, term_rdata;
  logic              sfx_we;
  logic [SW:0]       sfx_wdata, sfx_rdata;
  logic [SW:0]       add_res;

  assign term_we    = (state_q == S_INIT) || (state_q == S_WRITE);
  assign term_wdata = (state_q == S_INIT) ? t0 : t_div;
  assign t0         = ((mode_q == taylor_pkg::MODE_SIN) || (mode_q == taylor_pkg::MODE_LN1P))
                      ? mop_q : taylor_pkg::ONE_Q32;
  assign add_res    = sat_add(sum_q, term_rdata);
  assign sfx_we     = (state_q == S_REV_ADD);
  assign sfx_wdata  = {ovf_q | add_res[SW], add_res[SW-1:0]};

  taylor_ram #(.WIDTH(SW), .DEPTH(MAX_TERMS)) u_term_ram (
    .clk_i   (clk_i),
    .we_i    (term_we),
    .waddr_i (i_q[AW-1:0]),
    .wdata_i (term_wdata),
    .raddr_i (i_q[AW-1:0]),
    .rdata_o (term_rdata)
  );

  taylor_ram #(.WIDTH(SW + 1), .DEPTH(MAX_TERMS)) u_sfx_ram (
    .clk_i   (clk_i),
    .we_i    (sfx_we),
    .waddr_i (i_q[AW-1:0]),
    .wdata_i (sfx_wdata),
    .raddr_i (i_q[AW-1:0]),
    .rdata_o (sfx_rdata)
  );

  logic slot_free, in_beat, out_beat, last_i, out_load;
  assign slot_free = !out_valid_q || out_o.ready;
  assign in_beat   = in_i.valid && (state_q == S_IDLE);
  assign out_beat  = out_valid_q && out_o.ready;
  assign last_i    = (i_q == n_q - CW'(1));
  // Output register takes a new beat in the emitting states
  assign out_load  = slot_free && ((state_q == S_DOM) || (state_q == S_FWD_ADD) ||
                                   (state_q == S_OUT_EMIT));

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= taylor_pkg::TERM_COUNT_RST;
    end else if (cfg_we_i) begin
      tc_q <= cfg_wdata_i;
    end
  end

  // Sequencer with datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= N_MIN;
      i_q         <= '0;
      mode_q      <= taylor_pkg::MODE_SIN;
      xneg_q      <= 1'b0;
      xmag_q      <= '0;
      mop_q       <= '0;
      second_q    <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      divisor_q   <= '0;
      dq_q        <= '0;
      rem_q       <= '0;
      dcnt_q      <= '0;
      dneg_q      <= 1'b0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_sum_q   <= '0;
      out_idx_q   <= '0;
      out_rev_q   <= 1'b0;
      out_dom_q   <= 1'b0;
      out_ovf_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_beat) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            mode_q   <= in_mode;
            xneg_q   <= in_i.x_value[XW-1];
            xmag_q   <= in_i.x_value[XW-1] ? (~in_i.x_value + XW'(1)) : in_i.x_value;
            mop_q    <= {{(SW-XW-4){in_i.x_value[XW-1]}}, in_i.x_value, 4'b0};
            n_q      <= n_clamp;
            i_q      <= '0;
            state_q  <= in_dom ? S_DOM : S_INIT;
          end
        end
        S_DOM: begin
          if (slot_free) begin
            out_sum_q   <= '0;
            out_idx_q   <= '0;
            out_rev_q   <= 1'b0;
            out_dom_q   <= 1'b1;
            out_ovf_q   <= 1'b0;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_INIT: begin
          // ln keeps the power x in mop; others keep term 0
          mop_q    <= t0;
          second_q <= (mode_q == taylor_pkg::MODE_SIN) || (mode_q == taylor_pkg::MODE_COS);
          i_q      <= CW'(1);
          state_q  <= S_MUL_LO;
        end
        S_MUL_LO: begin
          lo_q      <= prod;
          divisor_q <= divisor;
          state_q   <= S_MUL_HI;
        end
        S_MUL_HI: begin
          hi_q    <= prod;
          state_q <= S_MUL_FIX;
        end
        S_MUL_FIX: begin
          mop_q <= mres;
          if (second_q) begin
            second_q <= 1'b0;
            state_q  <= S_MUL_LO;
          end else begin
            dq_q    <= mres_mag;
            rem_q   <= '0;
            dneg_q  <= mres[SW-1] ^ negate;
            dcnt_q  <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          dq_q   <= dq_d;
          rem_q  <= rem_d;
          dcnt_q <= dcnt_q + DCW'(1);
          if (dcnt_q == DC_END) begin
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (mode_q != taylor_pkg::MODE_LN1P) begin
            mop_q <= t_div;
          end
          second_q <= (mode_q == taylor_pkg::MODE_SIN) || (mode_q == taylor_pkg::MODE_COS);
          if (last_i) begin
            i_q     <= '0;
            sum_q   <= '0;
            ovf_q   <= 1'b0;
            state_q <= S_FWD_RD;
          end else begin
            i_q     <= i_q + CW'(1);
            state_q <= S_MUL_LO;
          end
        end
        S_FWD_RD: begin
          state_q <= S_FWD_ADD;
        end
        S_FWD_ADD: begin
          if (slot_free) begin
            out_sum_q   <= add_res[SW-1:0];
            out_idx_q   <= 5'(i_q);
            out_rev_q   <= 1'b0;
            out_dom_q   <= 1'b0;
            out_ovf_q   <= ovf_q | add_res[SW];
            out_last_q  <= 1'b0;
            if (last_i) begin
              sum_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_REV_RD;
            end else begin
              sum_q   <= add_res[SW-1:0];
              ovf_q   <= ovf_q | add_res[SW];
              i_q     <= i_q + CW'(1);
              state_q <= S_FWD_RD;
            end
          end
        end
        S_REV_RD: begin
          state_q <= S_REV_ADD;
        end
        S_REV_ADD: begin
          sum_q <= add_res[SW-1:0];
          ovf_q <= ovf_q | add_res[SW];
          if (i_q == '0) begin
            state_q <= S_OUT_RD;
          end else begin
            i_q     <= i_q - CW'(1);
            state_q <= S_REV_RD;
          end
        end
        S_OUT_RD: begin
          state_q <= S_OUT_EMIT;
        end
        S_OUT_EMIT: begin
          if (slot_free) begin
            out_sum_q   <= sfx_rdata[SW-1:0];
            out_idx_q   <= 5'(i_q);
            out_rev_q   <= 1'b1;
            out_dom_q   <= 1'b0;
            out_ovf_q   <= sfx_rdata[SW];
            out_last_q  <= last_i;
            if (last_i) begin
              state_q <= S_IDLE;
            end else begin
              i_q     <= i_q + CW'(1);
              state_q <= S_OUT_RD;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.partial_sum   = out_sum_q;
  assign out_o.term_index    = out_idx_q;
  assign out_o.reverse_order = out_rev_q;
  assign out_o.domain_error  = out_dom_q;
  assign out_o.overflowed    = out_ovf_q;
  assign out_o.last_result   = out_last_q;

  // Checks
  a_dom_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.domain_error |-> out_o.last_result && (out_o.partial_sum == '0))
    else $error("domain error beat malformed");

  a_last_rev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last_result && !out_o.domain_error |-> out_o.reverse_order)
    else $error("last beat is not a suffix sum");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("argument taken while busy");

  a_term_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> (i_q != '0) && (i_q < n_q))
    else $error("term index out of range");

endmodule
